@@ hw/rtl/bdg_pkg.sv @@
// ----------------------------------------------------------------------------
// bdg_pkg
// Types, code constants and glyph tables for the box-drawing pixel generator.
// ----------------------------------------------------------------------------
package bdg_pkg;

    typedef struct packed {
        logic [15:0] code_point;
        logic [5:0]  pixel_x;
        logic [5:0]  pixel_y;
    } t_in_beat;

    typedef struct packed {
        logic pixel_on;
        logic not_provided;
    } t_out_beat;

    typedef struct packed {
        logic [6:0] width;
        logic [6:0] height;
    } t_tile;

    // 5x5 pattern: [row][column]
    typedef logic [4:0][4:0] t_pat;

    localparam logic [1:0] ARM_NONE   = 2'd0;
    localparam logic [1:0] ARM_LIGHT  = 2'd1;
    localparam logic [1:0] ARM_HEAVY  = 2'd2;
    localparam logic [1:0] ARM_DOUBLE = 2'd3;

    localparam logic [15:0] CODE_REPLACEMENT = 16'hFFFD;
    localparam logic [8:0]  CODE_BOX_BLOCK   = 9'h04A;
    localparam logic [15:0] CODE_DBL_HORIZ   = 16'h2550;
    localparam logic [15:0] CODE_DBL_VERT    = 16'h2551;
    localparam logic [15:0] CODE_DOWN_SGL_RD = 16'h2552;
    localparam logic [15:0] CODE_DOWN_DBL_RS = 16'h2553;
    localparam logic [15:0] CODE_DBL_DOWN_R  = 16'h2554;
    localparam logic [15:0] CODE_UP_SGL_LD   = 16'h255B;
    localparam logic [15:0] CODE_DBL_CROSS   = 16'h256C;

    localparam logic [0:0] REG_TILE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_TILE_HEIGHT = 1'b1;

    function automatic logic [7:0] arms(input logic [1:0] l, input logic [1:0] t,
                                        input logic [1:0] r, input logic [1:0] b);
        return {b, r, t, l};
    endfunction

    localparam logic [7:0] ARM_TABLE [0:127] = '{
        arms(1,0,1,0), arms(2,0,2,0), arms(0,1,0,1), arms(0,2,0,2),
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        arms(0,0,1,1), arms(0,0,2,1), arms(0,0,1,2), arms(0,0,2,2),
        arms(1,0,0,1), arms(2,0,0,1), arms(1,0,0,2), arms(2,0,0,2),
        arms(0,1,1,0), arms(0,1,2,0), arms(0,2,1,0), arms(0,2,2,0),
        arms(1,1,0,0), arms(2,1,0,0), arms(1,2,0,0), arms(2,2,0,0),
        arms(0,1,1,1), arms(0,1,2,1), arms(0,2,1,1), arms(0,1,1,2),
        arms(0,2,1,2), arms(0,2,2,1), arms(0,1,2,2), arms(0,2,2,2),
        arms(1,1,0,1), arms(2,1,0,1), arms(1,2,0,1), arms(1,1,0,2),
        arms(1,2,0,2), arms(2,2,0,1), arms(2,1,0,2), arms(2,2,0,2),
        arms(1,0,1,1), arms(2,0,1,1), arms(1,0,2,1), arms(2,0,2,1),
        arms(1,0,1,2), arms(2,0,1,2), arms(1,0,2,2), arms(2,2,0,2),
        arms(1,1,1,0), arms(2,1,1,0), arms(1,1,2,0), arms(2,1,2,0),
        arms(1,2,1,0), arms(2,2,1,0), arms(0,2,1,2), arms(2,2,0,2),
        arms(1,1,1,1), arms(2,1,1,1), arms(1,1,2,1), arms(2,1,2,1),
        arms(1,2,1,1), arms(1,1,1,2), arms(1,2,1,2), arms(2,2,1,1),
        arms(1,2,2,1), arms(2,1,1,2), arms(1,1,2,2), arms(2,2,2,1),
        arms(2,1,2,2), arms(2,2,1,2), arms(1,2,2,2), arms(2,2,2,2),
        8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        arms(3,0,0,1), arms(1,0,0,3), arms(3,0,0,3), arms(0,1,3,0),
        arms(0,3,1,0), arms(0,3,3,0), 8'd0,          arms(1,3,0,0),
        arms(3,3,0,0), arms(0,1,3,1), arms(0,3,1,3), arms(0,3,3,3),
        arms(3,1,0,1), arms(1,3,0,3), arms(3,3,0,3), arms(3,0,3,1),
        arms(1,0,1,3), arms(3,0,3,3), arms(3,1,3,0), arms(1,3,1,0),
        arms(3,3,3,0), arms(3,1,3,1), arms(1,3,1,3), 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    function automatic t_pat pattern_of(input logic [15:0] code);
        t_pat p;
        unique case (code)
            CODE_DBL_HORIZ:   p = {5'b00000, 5'b11111, 5'b00000, 5'b11111, 5'b00000};
            CODE_DBL_VERT:    p = {5'b01010, 5'b01010, 5'b01010, 5'b01010, 5'b01010};
            CODE_DOWN_SGL_RD: p = {5'b00100, 5'b11100, 5'b00100, 5'b11100, 5'b00000};
            CODE_DOWN_DBL_RS: p = {5'b01010, 5'b01010, 5'b11110, 5'b00000, 5'b00000};
            CODE_DBL_DOWN_R:  p = {5'b01010, 5'b11010, 5'b00010, 5'b11110, 5'b00000};
            CODE_UP_SGL_LD:   p = {5'b00000, 5'b00111, 5'b00100, 5'b00111, 5'b00100};
            CODE_DBL_CROSS:   p = {5'b01010, 5'b11011, 5'b00000, 5'b11011, 5'b01010};
            default:          p = '0;
        endcase
        return p;
    endfunction

    // Center 3x3 fill, bit = row*3 + column
    function automatic logic [8:0] center_mask(input logic [1:0] l, input logic [1:0] t,
                                               input logic [1:0] r, input logic [1:0] b);
        logic [8:0] m;
        m = '0;
        if (t == ARM_LIGHT && b == ARM_LIGHT) m |= 9'b010010010;
        if (l == ARM_LIGHT && r == ARM_LIGHT) m |= 9'b000111000;
        if (l == ARM_LIGHT && t == ARM_LIGHT) m |= 9'b000011010;
        if (t == ARM_LIGHT && r == ARM_LIGHT) m |= 9'b000110010;
        if (r == ARM_LIGHT && b == ARM_LIGHT) m |= 9'b010110000;
        if (b == ARM_LIGHT && l == ARM_LIGHT) m |= 9'b010011000;
        if ((l == ARM_HEAVY && t == ARM_HEAVY) || (t == ARM_HEAVY && r == ARM_HEAVY) ||
            (r == ARM_HEAVY && b == ARM_HEAVY) || (b == ARM_HEAVY && l == ARM_HEAVY) ||
            (t == ARM_HEAVY && b == ARM_HEAVY) || (l == ARM_HEAVY && r == ARM_HEAVY))
            m |= 9'b111111111;
        if (l == ARM_LIGHT && t == ARM_HEAVY) m |= 9'b000011111;
        if (l == ARM_HEAVY && t == ARM_LIGHT) m |= 9'b001011011;
        if (t == ARM_LIGHT && r == ARM_HEAVY) m |= 9'b100110110;
        if (t == ARM_HEAVY && r == ARM_LIGHT) m |= 9'b000110111;
        if (r == ARM_LIGHT && b == ARM_HEAVY) m |= 9'b111110000;
        if (r == ARM_HEAVY && b == ARM_LIGHT) m |= 9'b110110100;
        if (b == ARM_LIGHT && l == ARM_HEAVY) m |= 9'b011011001;
        if (b == ARM_HEAVY && l == ARM_LIGHT) m |= 9'b111011000;
        if (l == ARM_DOUBLE && t == ARM_DOUBLE && r == ARM_DOUBLE && b == ARM_DOUBLE) begin
            m |= 9'b101000101;
        end else begin
            if (l == ARM_DOUBLE && r == ARM_DOUBLE) m |= 9'b111000111;
            if (t == ARM_DOUBLE && b == ARM_DOUBLE) m |= 9'b101101101;
            if (l == ARM_DOUBLE && t == ARM_DOUBLE) m |= 9'b111100101;
            if (t == ARM_DOUBLE && r == ARM_DOUBLE) m |= 9'b111001101;
            if (r == ARM_DOUBLE && b == ARM_DOUBLE) m |= 9'b101001111;
            if (b == ARM_DOUBLE && l == ARM_DOUBLE) m |= 9'b101100111;
        end
        return m;
    endfunction

    // Stroke from (x1,y1) to (x2,y2): light is one pixel wide, heavy three, double two pixels at +-1
    function automatic logic on_line(input logic signed [8:0] px, input logic signed [8:0] py,
                                     input logic signed [8:0] x1, input logic signed [8:0] y1,
                                     input logic signed [8:0] x2, input logic signed [8:0] y2,
                                     input logic [1:0] style);
        logic signed [8:0] a;
        logic signed [8:0] c;
        logic              span;
        logic              hit;
        if (x1 == x2) begin
            span = (py >= y1) && (py <= y2);
            a    = px;
            c    = x1;
        end else begin
            span = (px >= x1) && (px <= x2);
            a    = py;
            c    = y1;
        end
        unique case (style)
            ARM_LIGHT:  hit = (a == c);
            ARM_HEAVY:  hit = (a >= c - 9'sd1) && (a <= c + 9'sd1);
            ARM_DOUBLE: hit = (a == c - 9'sd1) || (a == c + 9'sd1);
            default:    hit = 1'b0;
        endcase
        return span && hit;
    endfunction

endpackage

@@ hw/rtl/bdg_cfg.sv @@
// ----------------------------------------------------------------------------
// bdg_cfg
// Tile size registers on the APB port; sides clamp to the largest tile.
// ----------------------------------------------------------------------------
module bdg_cfg
    import bdg_pkg::*;
#(
    parameter int MAX_TILE_SIDE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_tile       o_tile
);

    localparam int         SatSide  = (MAX_TILE_SIDE > 127) ? 127 : MAX_TILE_SIDE;
    localparam logic [6:0] SAT_SIDE = 7'(SatSide);

    logic [6:0] r_width;
    logic [6:0] r_height;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 7'd8;
            r_height <= 7'd16;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_TILE_WIDTH:  r_width  <= pwdata[6:0];
                REG_TILE_HEIGHT: r_height <= pwdata[6:0];
                default:         r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TILE_WIDTH:  prdata = {25'd0, r_width};
            REG_TILE_HEIGHT: prdata = {25'd0, r_height};
            default:         prdata = '0;
        endcase
    end

    assign o_tile.width  = (r_width  > SAT_SIDE) ? SAT_SIDE : r_width;
    assign o_tile.height = (r_height > SAT_SIDE) ? SAT_SIDE : r_height;

endmodule

@@ hw/rtl/bdg_glyph.sv @@
// ----------------------------------------------------------------------------
// bdg_glyph
// Pixel decision for one code point and position: pattern, arms or outline.
// ----------------------------------------------------------------------------
module bdg_glyph
    import bdg_pkg::*;
(
    input  t_in_beat  i_beat,
    input  t_tile     i_tile,
    output t_out_beat o_beat
);

    logic signed [8:0] px, py, w, h;
    logic signed [8:0] cx, cy, cl, ct, cr, cb;
    logic              in_cx, in_cy;
    logic [1:0]        dx, dy;
    logic [2:0]        pcol, prow;
    logic [3:0]        sq_idx;
    logic              provided, in_tile;
    t_pat              pat;
    logic [7:0]        arm_code;
    logic [1:0]        al, at, ar, ab;
    logic [8:0]        mask;
    logic              arm_on, pat_on, box_on;

    always_comb begin
        px = signed'({3'd0, i_beat.pixel_x});
        py = signed'({3'd0, i_beat.pixel_y});
        w  = signed'({2'd0, i_tile.width});
        h  = signed'({2'd0, i_tile.height});
        cx = (w - 9'sd1) >>> 1;
        cy = (h - 9'sd1) >>> 1;
        cl = cx - 9'sd1;
        ct = cy - 9'sd1;
        cr = cx + 9'sd2;
        cb = cy + 9'sd2;

        in_cx  = (px >= cx - 9'sd1) && (px <= cx + 9'sd1);
        in_cy  = (py >= cy - 9'sd1) && (py <= cy + 9'sd1);
        dx     = 2'(px - cx + 9'sd1);
        dy     = 2'(py - cy + 9'sd1);
        pcol   = {1'b0, dx} + 3'd1;
        prow   = {1'b0, dy} + 3'd1;
        sq_idx = {2'd0, dy} * 4'd3 + {2'd0, dx};

        provided = (i_beat.code_point == CODE_REPLACEMENT) ||
                   (i_beat.code_point[15:7] == CODE_BOX_BLOCK);
        in_tile  = (px < w) && (py < h);

        pat      = pattern_of(i_beat.code_point);
        arm_code = ARM_TABLE[i_beat.code_point[6:0]];
        al       = arm_code[1:0];
        at       = arm_code[3:2];
        ar       = arm_code[5:4];
        ab       = arm_code[7:6];
        mask     = center_mask(al, at, ar, ab);

        if (w < 9'sd3 || h < 9'sd3) begin
            arm_on = 1'b0;
        end else begin
            arm_on = ((al != ARM_NONE) && (cl > 9'sd0) &&
                      on_line(px, py, 9'sd0, cy, cl - 9'sd1, cy, al)) ||
                     ((at != ARM_NONE) && (ct > 9'sd0) &&
                      on_line(px, py, cx, 9'sd0, cx, ct - 9'sd1, at)) ||
                     ((ar != ARM_NONE) && (cr < w) &&
                      on_line(px, py, cr, cy, w - 9'sd1, cy, ar)) ||
                     ((ab != ARM_NONE) && (cb < h) &&
                      on_line(px, py, cx, cb, cx, h - 9'sd1, ab)) ||
                     (in_cx && in_cy && mask[sq_idx]);
        end

        pat_on = (in_cx && in_cy && pat[prow][pcol]) ||
                 (in_cy && ((pat[prow][0] && (px < cl)) || (pat[prow][4] && (px >= cr)))) ||
                 (in_cx && ((pat[0][pcol] && (py < ct)) || (pat[4][pcol] && (py >= cb))));

        box_on = (((py == 9'sd1) || (py == h - 9'sd2)) && (px >= 9'sd1) && (px <= w - 9'sd2)) ||
                 (((px == 9'sd1) || (px == w - 9'sd2)) && (py >= 9'sd1) && (py <= h - 9'sd2));

        o_beat.not_provided = !provided;
        if (!(provided && in_tile)) begin
            o_beat.pixel_on = 1'b0;
        end else if (pat != '0) begin
            o_beat.pixel_on = pat_on;
        end else if (arm_code != 8'd0) begin
            o_beat.pixel_on = arm_on;
        end else begin
            o_beat.pixel_on = box_on;
        end
    end

endmodule

@@ hw/rtl/box_drawing_glyph_pixel_generator.sv @@
// ----------------------------------------------------------------------------
// box_drawing_glyph_pixel_generator
// Takes one beat per clock unless held off: a code point and a pixel
// position, and returns whether that pixel of the drawn glyph is lit, plus a
// flag for codes outside the box-drawing set and the replacement character.
// Throughput is one pixel per cycle without stalls; an input register is
// followed by a result register with one combinational glyph pass between.
// Input stays ready unless the result register stalls with the input one
// full. Tile width and height are written over APB at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module box_drawing_glyph_pixel_generator
    import bdg_pkg::*;
#(
    parameter int MAX_TILE_SIDE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_beat    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_beat   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_tile     tile;
    t_in_beat  r_s1_data;
    logic      r_s1_vld;
    t_out_beat r_out_data;
    logic      r_out_vld;
    t_out_beat glyph_beat;
    logic      stall;

    bdg_cfg #(
        .MAX_TILE_SIDE (MAX_TILE_SIDE)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_tile  (tile)
    );

    bdg_glyph u_glyph (
        .i_beat (r_s1_data),
        .i_tile (tile),
        .o_beat (glyph_beat)
    );

    assign stall      = r_out_vld && !i_out_ready;
    assign o_in_ready = !(stall && r_s1_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!stall) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall && r_s1_vld) begin
            r_out_data <= glyph_beat;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_vld && o_out_valid))
        else $error("input held off while a stage is empty");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !stall) |=> o_out_valid)
        else $error("staged beat did not reach the result register");

    a_dark_when_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.not_provided) |-> !o_out_data.pixel_on)
        else $error("pixel lit for an unsupported code");
`endif

endmodule

@@ bench/bdg_pixel_checker.sv @@
// ----------------------------------------------------------------------------
// bdg_pixel_checker
// Watches the pixel request and result channels and the APB port of the
// box-drawing pixel generator. It keeps its own copy of the tile size and
// works out, for every request beat, whether the pixel should be lit and
// whether the code is outside the drawn set. Result beats are checked in
// order against those predictions, and every mismatch is counted.
// ----------------------------------------------------------------------------
module bdg_pixel_checker
    import bdg_pkg::*;
#(
    parameter int MAX_TILE_SIDE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_beat    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_beat   i_out_data,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_mismatches,
    output int          o_pending
);

    localparam logic [6:0]  TILE_W_RESET = 7'd8;
    localparam logic [6:0]  TILE_H_RESET = 7'd16;
    localparam logic [15:0] BOX_FIRST    = 16'h2500;
    localparam logic [15:0] BOX_ARM_LAST = 16'h256C;
    localparam logic [15:0] BOX_LAST     = 16'h257F;

    localparam logic [1:0] NO = ARM_NONE;
    localparam logic [1:0] LT = ARM_LIGHT;
    localparam logic [1:0] HV = ARM_HEAVY;
    localparam logic [1:0] DB = ARM_DOUBLE;

    logic [6:0] tile_w;
    logic [6:0] tile_h;
    logic [7:0] arm_lut [0:108];
    t_out_beat  lit_expect_q [$];
    int         mismatches = 0;
    int         pending = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = pending;

    // arm styles packed as {left, top, right, bottom}
    function automatic logic [7:0] arm_set(input logic [1:0] l, input logic [1:0] t,
                                           input logic [1:0] r, input logic [1:0] b);
        return {l, t, r, b};
    endfunction

    initial begin
        arm_lut = '{
            arm_set(LT,NO,LT,NO), arm_set(HV,NO,HV,NO), arm_set(NO,LT,NO,LT), arm_set(NO,HV,NO,HV),
            8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
            arm_set(NO,NO,LT,LT), arm_set(NO,NO,HV,LT), arm_set(NO,NO,LT,HV), arm_set(NO,NO,HV,HV),
            arm_set(LT,NO,NO,LT), arm_set(HV,NO,NO,LT), arm_set(LT,NO,NO,HV), arm_set(HV,NO,NO,HV),
            arm_set(NO,LT,LT,NO), arm_set(NO,LT,HV,NO), arm_set(NO,HV,LT,NO), arm_set(NO,HV,HV,NO),
            arm_set(LT,LT,NO,NO), arm_set(HV,LT,NO,NO), arm_set(LT,HV,NO,NO), arm_set(HV,HV,NO,NO),
            arm_set(NO,LT,LT,LT), arm_set(NO,LT,HV,LT), arm_set(NO,HV,LT,LT), arm_set(NO,LT,LT,HV),
            arm_set(NO,HV,LT,HV), arm_set(NO,HV,HV,LT), arm_set(NO,LT,HV,HV), arm_set(NO,HV,HV,HV),
            arm_set(LT,LT,NO,LT), arm_set(HV,LT,NO,LT), arm_set(LT,HV,NO,LT), arm_set(LT,LT,NO,HV),
            arm_set(LT,HV,NO,HV), arm_set(HV,HV,NO,LT), arm_set(HV,LT,NO,HV), arm_set(HV,HV,NO,HV),
            arm_set(LT,NO,LT,LT), arm_set(HV,NO,LT,LT), arm_set(LT,NO,HV,LT), arm_set(HV,NO,HV,LT),
            arm_set(LT,NO,LT,HV), arm_set(HV,NO,LT,HV), arm_set(LT,NO,HV,HV), arm_set(HV,HV,NO,HV),
            arm_set(LT,LT,LT,NO), arm_set(HV,LT,LT,NO), arm_set(LT,LT,HV,NO), arm_set(HV,LT,HV,NO),
            arm_set(LT,HV,LT,NO), arm_set(HV,HV,LT,NO), arm_set(NO,HV,LT,HV), arm_set(HV,HV,NO,HV),
            arm_set(LT,LT,LT,LT), arm_set(HV,LT,LT,LT), arm_set(LT,LT,HV,LT), arm_set(HV,LT,HV,LT),
            arm_set(LT,HV,LT,LT), arm_set(LT,LT,LT,HV), arm_set(LT,HV,LT,HV), arm_set(HV,HV,LT,LT),
            arm_set(LT,HV,HV,LT), arm_set(HV,LT,LT,HV), arm_set(LT,LT,HV,HV), arm_set(HV,HV,HV,LT),
            arm_set(HV,LT,HV,HV), arm_set(HV,HV,LT,HV), arm_set(LT,HV,HV,HV), arm_set(HV,HV,HV,HV),
            8'd0, 8'd0, 8'd0, 8'd0,
            8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
            arm_set(DB,NO,NO,LT), arm_set(LT,NO,NO,DB), arm_set(DB,NO,NO,DB), arm_set(NO,LT,DB,NO),
            arm_set(NO,DB,LT,NO), arm_set(NO,DB,DB,NO), 8'd0,                 arm_set(LT,DB,NO,NO),
            arm_set(DB,DB,NO,NO), arm_set(NO,LT,DB,LT), arm_set(NO,DB,LT,DB), arm_set(NO,DB,DB,DB),
            arm_set(DB,LT,NO,LT), arm_set(LT,DB,NO,DB), arm_set(DB,DB,NO,DB), arm_set(DB,NO,DB,LT),
            arm_set(LT,NO,LT,DB), arm_set(DB,NO,DB,DB), arm_set(DB,LT,DB,NO), arm_set(LT,DB,LT,NO),
            arm_set(DB,DB,DB,NO), arm_set(DB,LT,DB,LT), arm_set(LT,DB,LT,DB), 8'd0
        };
    end

    // 5x5 patterns, row r in bits [5r+4:5r], column c at bit 5r+c
    function automatic logic [24:0] glyph_pattern(input logic [15:0] code);
        case (code)
            CODE_DBL_HORIZ:   return {5'b00000, 5'b11111, 5'b00000, 5'b11111, 5'b00000};
            CODE_DBL_VERT:    return {5'b01010, 5'b01010, 5'b01010, 5'b01010, 5'b01010};
            CODE_DOWN_SGL_RD: return {5'b00100, 5'b11100, 5'b00100, 5'b11100, 5'b00000};
            CODE_DOWN_DBL_RS: return {5'b01010, 5'b01010, 5'b11110, 5'b00000, 5'b00000};
            CODE_DBL_DOWN_R:  return {5'b01010, 5'b11010, 5'b00010, 5'b11110, 5'b00000};
            CODE_UP_SGL_LD:   return {5'b00000, 5'b00111, 5'b00100, 5'b00111, 5'b00100};
            CODE_DBL_CROSS:   return {5'b01010, 5'b11011, 5'b00000, 5'b11011, 5'b01010};
            default:          return '0;
        endcase
    endfunction

    // 3x3 square written as it looks: leftmost character is column 0
    function automatic logic [8:0] sq9(input logic [2:0] r0, input logic [2:0] r1,
                                       input logic [2:0] r2);
        return {r2[0], r2[1], r2[2], r1[0], r1[1], r1[2], r0[0], r0[1], r0[2]};
    endfunction

    function automatic logic [8:0] junction_fill(input logic [1:0] l, input logic [1:0] t,
                                                 input logic [1:0] r, input logic [1:0] b);
        logic [8:0] m;
        m = '0;
        if (t == LT && b == LT) m |= sq9(3'b010, 3'b010, 3'b010);
        if (l == LT && r == LT) m |= sq9(3'b000, 3'b111, 3'b000);
        if (l == LT && t == LT) m |= sq9(3'b010, 3'b110, 3'b000);
        if (t == LT && r == LT) m |= sq9(3'b010, 3'b011, 3'b000);
        if (r == LT && b == LT) m |= sq9(3'b000, 3'b011, 3'b010);
        if (b == LT && l == LT) m |= sq9(3'b000, 3'b110, 3'b010);
        if ((l == HV && t == HV) || (t == HV && r == HV) || (r == HV && b == HV) ||
            (b == HV && l == HV) || (t == HV && b == HV) || (l == HV && r == HV))
            m |= sq9(3'b111, 3'b111, 3'b111);
        if (l == LT && t == HV) m |= sq9(3'b111, 3'b110, 3'b000);
        if (l == HV && t == LT) m |= sq9(3'b110, 3'b110, 3'b100);
        if (t == LT && r == HV) m |= sq9(3'b011, 3'b011, 3'b001);
        if (t == HV && r == LT) m |= sq9(3'b111, 3'b011, 3'b000);
        if (r == LT && b == HV) m |= sq9(3'b000, 3'b011, 3'b111);
        if (r == HV && b == LT) m |= sq9(3'b001, 3'b011, 3'b011);
        if (b == LT && l == HV) m |= sq9(3'b100, 3'b110, 3'b110);
        if (b == HV && l == LT) m |= sq9(3'b000, 3'b110, 3'b111);
        if (l == DB && t == DB && r == DB && b == DB) begin
            m |= sq9(3'b101, 3'b000, 3'b101);
        end else begin
            if (l == DB && r == DB) m |= sq9(3'b111, 3'b000, 3'b111);
            if (t == DB && b == DB) m |= sq9(3'b101, 3'b101, 3'b101);
            if (l == DB && t == DB) m |= sq9(3'b101, 3'b001, 3'b111);
            if (t == DB && r == DB) m |= sq9(3'b101, 3'b100, 3'b111);
            if (r == DB && b == DB) m |= sq9(3'b111, 3'b100, 3'b101);
            if (b == DB && l == DB) m |= sq9(3'b111, 3'b001, 3'b101);
        end
        return m;
    endfunction

    function automatic logic stroke_hit(input int px, input int py, input int x1, input int y1,
                                        input int x2, input int y2, input logic [1:0] style);
        int a;
        int c;
        if (x1 == x2) begin
            if (py < y1 || py > y2) return 1'b0;
            a = px;
            c = x1;
        end else begin
            if (px < x1 || px > x2) return 1'b0;
            a = py;
            c = y1;
        end
        case (style)
            LT:      return a == c;
            HV:      return a >= c - 1 && a <= c + 1;
            DB:      return a == c - 1 || a == c + 1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic arm_glyph_lit(input int px, input int py, input int w, input int h,
                                           input logic [7:0] arms);
        logic [1:0] l;
        logic [1:0] t;
        logic [1:0] r;
        logic [1:0] b;
        logic [8:0] m;
        int cx;
        int cy;
        int cl;
        int ct;
        int cr;
        int cb;
        {l, t, r, b} = arms;
        cx = (w - 1) / 2;
        cy = (h - 1) / 2;
        cl = cx - 1;
        ct = cy - 1;
        cr = cl + 3;
        cb = ct + 3;
        if (w < 3 || h < 3) return 1'b0;
        if (l != NO && cl > 0 && stroke_hit(px, py, 0, cy, cl - 1, cy, l)) return 1'b1;
        if (t != NO && ct > 0 && stroke_hit(px, py, cx, 0, cx, ct - 1, t)) return 1'b1;
        if (r != NO && cr < w && stroke_hit(px, py, cr, cy, w - 1, cy, r)) return 1'b1;
        if (b != NO && cb < h && stroke_hit(px, py, cx, cb, cx, h - 1, b)) return 1'b1;
        m = junction_fill(l, t, r, b);
        if (px >= cx - 1 && px <= cx + 1 && py >= cy - 1 && py <= cy + 1)
            return m[(py - cy + 1) * 3 + (px - cx + 1)];
        return 1'b0;
    endfunction

    function automatic logic pattern_glyph_lit(input int px, input int py, input int w,
                                               input int h, input logic [24:0] p);
        int cx;
        int cy;
        int cl;
        int ct;
        int cr;
        int cb;
        cx = (w - 1) / 2;
        cy = (h - 1) / 2;
        cl = cx - 1;
        ct = cy - 1;
        cr = cl + 3;
        cb = ct + 3;
        if (px >= cx - 1 && px <= cx + 1 && py >= cy - 1 && py <= cy + 1 &&
            p[(py - cy + 2) * 5 + (px - cx + 2)])
            return 1'b1;
        for (int d = -1; d <= 1; d++) begin
            if (py == cy + d) begin
                if (p[(d + 2) * 5] && px < cl) return 1'b1;
                if (p[(d + 2) * 5 + 4] && px >= cr) return 1'b1;
            end
            if (px == cx + d) begin
                if (p[d + 2] && py < ct) return 1'b1;
                if (p[22 + d] && py >= cb) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic outline_lit(input int px, input int py, input int w, input int h);
        if ((py == 1 || py == h - 2) && px >= 1 && px <= w - 2) return 1'b1;
        if ((px == 1 || px == w - 2) && py >= 1 && py <= h - 2) return 1'b1;
        return 1'b0;
    endfunction

    function automatic t_out_beat predict_pixel(input t_in_beat req, input logic [6:0] w_reg,
                                                input logic [6:0] h_reg);
        t_out_beat   res;
        logic        provided;
        logic [24:0] pat;
        logic [7:0]  arms;
        int          w;
        int          h;
        int          px;
        int          py;
        w  = (w_reg > MAX_TILE_SIDE) ? MAX_TILE_SIDE : int'(w_reg);
        h  = (h_reg > MAX_TILE_SIDE) ? MAX_TILE_SIDE : int'(h_reg);
        px = int'(req.pixel_x);
        py = int'(req.pixel_y);
        provided = req.code_point == CODE_REPLACEMENT ||
                   (req.code_point >= BOX_FIRST && req.code_point <= BOX_LAST);
        res.pixel_on     = 1'b0;
        res.not_provided = !provided;
        if (provided && px < w && py < h) begin
            pat  = glyph_pattern(req.code_point);
            arms = 8'd0;
            if (req.code_point >= BOX_FIRST && req.code_point <= BOX_ARM_LAST)
                arms = arm_lut[req.code_point - BOX_FIRST];
            if (pat != '0)
                res.pixel_on = pattern_glyph_lit(px, py, w, h, pat);
            else if (arms != 8'd0)
                res.pixel_on = arm_glyph_lit(px, py, w, h, arms);
            else
                res.pixel_on = outline_lit(px, py, w, h);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_beat want;
        if (!i_rst_n) begin
            lit_expect_q.delete();
            tile_w = TILE_W_RESET;
            tile_h = TILE_H_RESET;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_TILE_WIDTH)
                    tile_w = i_pwdata[6:0];
                else
                    tile_h = i_pwdata[6:0];
            end
            if (i_in_valid && i_in_ready)
                lit_expect_q.push_back(predict_pixel(i_in_data, tile_w, tile_h));
            if (i_out_valid && i_out_ready) begin
                if (lit_expect_q.size() == 0) begin
                    $error("result beat arrived with no pixel request pending");
                    mismatches++;
                end else begin
                    want = lit_expect_q.pop_front();
                    if (want.pixel_on !== i_out_data.pixel_on) begin
                        $error("pixel_on: expected %0b, got %0b",
                               want.pixel_on, i_out_data.pixel_on);
                        mismatches++;
                    end
                    if (want.not_provided !== i_out_data.not_provided) begin
                        $error("not_provided: expected %0b, got %0b",
                               want.not_provided, i_out_data.not_provided);
                        mismatches++;
                    end
                end
            end
        end
        pending = lit_expect_q.size();
    end

endmodule

@@ bench/box_drawing_glyph_pixel_generator_tb.sv @@
// ----------------------------------------------------------------------------
// box_drawing_glyph_pixel_generator_tb
// Drives pixel requests into the box-drawing pixel generator over a range of
// tile sizes, from empty and tiny cells up to and past the largest side.
// Each size after the first starts with an APB write pair while idle, then
// a run of requests aimed mostly at drawn codes and in-cell pixels, with
// random gaps on both channels but in one burst size. A checker beside the
// block predicts every result and counts mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
module box_drawing_glyph_pixel_generator_tb;
    import bdg_pkg::*;

    localparam int          MAX_TILE_SIDE = 64;
    localparam int          STALL_LIMIT   = 1000;
    localparam int          N_SIZES       = 14;
    localparam int          BURST_SIZE    = 5;
    localparam logic [15:0] BOX_FIRST     = 16'h2500;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_beat    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_beat   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int   mismatches;
    int   pending;
    logic idle_on = 1'b1;
    int   pixels_sent = 0;
    int   sizes_done = 0;

    int size_w [N_SIZES] = '{1, 2, 3, 4, 5, 64, 0, 10, 127, 65, 6, 33, 9, 7};
    int size_h [N_SIZES] = '{1, 5, 3, 4, 7, 64, 10, 0, 100, 3, 64, 17, 12, 2};

    t_in_beat opening_pixels [25] = '{
        '{16'h0000, 6'd0, 6'd0},          '{16'hFFFF, 6'd63, 6'd63},
        '{CODE_REPLACEMENT, 6'd1, 6'd1},  '{16'h24FF, 6'd3, 6'd7},
        '{16'h2580, 6'd3, 6'd7},          '{16'h257F, 6'd6, 6'd14},
        '{16'h256D, 6'd3, 6'd7},          '{16'h2500, 6'd0, 6'd7},
        '{16'h2500, 6'd7, 6'd7},          '{16'h2503, 6'd4, 6'd0},
        '{16'h2504, 6'd1, 6'd1},          '{CODE_DBL_HORIZ, 6'd0, 6'd6},
        '{CODE_DBL_VERT, 6'd4, 6'd15},    '{CODE_DOWN_SGL_RD, 6'd4, 6'd6},
        '{CODE_DOWN_DBL_RS, 6'd2, 6'd8},  '{CODE_DBL_DOWN_R, 6'd3, 6'd7},
        '{CODE_UP_SGL_LD, 6'd3, 6'd0},    '{CODE_DBL_CROSS, 6'd2, 6'd6},
        '{16'h2533, 6'd3, 6'd7},          '{16'h253A, 6'd4, 6'd8},
        '{16'h253B, 6'd2, 6'd6},          '{16'h256A, 6'd3, 6'd6},
        '{16'h254B, 6'd3, 6'd7},          '{16'h2500, 6'd8, 6'd7},
        '{16'h2557, 6'd2, 6'd15}
    };

    box_drawing_glyph_pixel_generator #(
        .MAX_TILE_SIDE(MAX_TILE_SIDE)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    bdg_pixel_checker #(
        .MAX_TILE_SIDE(MAX_TILE_SIDE)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // stall the result channel
    always @(negedge i_clk) begin
        i_out_ready <= !idle_on || ($urandom_range(99) >= 37);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (psel && penable && pwrite && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic logic [5:0] pick_coord(input int side);
        int k;
        int c;
        k = $urandom_range(99);
        if (side == 0 || k >= 70) return 6'($urandom_range(63));
        if (k < 35) begin
            c = (side - 1) / 2 + int'($urandom_range(4)) - 2;
            if (c < 0) c = 0;
            if (c > side - 1) c = side - 1;
            return 6'(c);
        end
        return 6'($urandom_range(side - 1));
    endfunction

    function automatic t_in_beat random_pixel(input int side_w, input int side_h);
        t_in_beat req;
        int       k;
        k = $urandom_range(99);
        if (k < 50) begin
            req.code_point = BOX_FIRST + 16'($urandom_range(16'h6C));
        end else if (k < 62) begin
            case ($urandom_range(6))
                0:       req.code_point = CODE_DBL_HORIZ;
                1:       req.code_point = CODE_DBL_VERT;
                2:       req.code_point = CODE_DOWN_SGL_RD;
                3:       req.code_point = CODE_DOWN_DBL_RS;
                4:       req.code_point = CODE_DBL_DOWN_R;
                5:       req.code_point = CODE_UP_SGL_LD;
                default: req.code_point = CODE_DBL_CROSS;
            endcase
        end else if (k < 72) begin
            req.code_point = 16'h256D + 16'($urandom_range(16'h12));
        end else if (k < 77) begin
            req.code_point = CODE_REPLACEMENT;
        end else if (k < 85) begin
            req.code_point = 16'h2480 + 16'($urandom_range(16'h17F));
        end else begin
            req.code_point = 16'($urandom);
        end
        req.pixel_x = pick_coord(side_w);
        req.pixel_y = pick_coord(side_h);
        return req;
    endfunction

    task automatic send_pixel(input t_in_beat req);
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pixels_sent++;
    endtask

    // drop valid and hold until every result beat is back
    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [0:0] reg_idx, input logic [6:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin : stimulus
        int side_w;
        int side_h;
        int n_items;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_pixels[i]) send_pixel(opening_pixels[i]);
        repeat (30) send_pixel(random_pixel(8, 16));
        drain();
        sizes_done++;

        for (int p = 0; p < N_SIZES; p++) begin
            apb_write(REG_TILE_WIDTH, 7'(size_w[p]));
            apb_write(REG_TILE_HEIGHT, 7'(size_h[p]));
            side_w  = (size_w[p] > MAX_TILE_SIDE) ? MAX_TILE_SIDE : size_w[p];
            side_h  = (size_h[p] > MAX_TILE_SIDE) ? MAX_TILE_SIDE : size_h[p];
            idle_on = (p != BURST_SIZE);
            n_items = idle_on ? 35 : 60;
            repeat (n_items) send_pixel(random_pixel(side_w, side_h));
            drain();
            idle_on = 1'b1;
            sizes_done++;
        end

        repeat (4) @(posedge i_clk);
        $display("%0d pixel requests over %0d tile sizes, empty and oversize sides included",
                 pixels_sent, sizes_done);
        $display("covered pattern, arm, outline and unsupported codes with random stalls");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ box_drawing_glyph_pixel_generator.f @@
hw/rtl/bdg_pkg.sv
hw/rtl/bdg_cfg.sv
hw/rtl/bdg_glyph.sv
hw/rtl/box_drawing_glyph_pixel_generator.sv
bench/bdg_pixel_checker.sv
bench/box_drawing_glyph_pixel_generator_tb.sv
